// ===== rtl/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg
// shared types, character codes and lookup functions for the text sanitiser
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int unsigned SGR_PARAM_DEPTH_DEF = 16;
  localparam int unsigned SGR_CAP_MAX         = 21;
  localparam int unsigned QUEUE_DEPTH         = 2;
  localparam logic [15:0] MAX_OUT_RESET       = 16'd4096;
  localparam int unsigned CUT_LEN             = 14;

  // character codes
  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_DEL  = 8'h7F;
  localparam logic [7:0] CH_LBR  = 8'h5B;
  localparam logic [7:0] CH_M    = 8'h6D;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_U    = 8'h75;

  // parse phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ESC  = 2'd1;
  localparam logic [1:0] PH_CSI  = 2'd2;
  localparam logic [1:0] PH_UTF8 = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       fin;
    logic       is_esc;
    logic       is_ctrl;
    logic       is_ascii;
    logic [2:0] lead_len;
    logic [4:0] lead_bits;
    logic       is_cont;
    logic       is_param;
    logic       is_m;
    logic       is_lbr;
  } item_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    hex_char = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h37 + {4'd0, nib});
  endfunction

  function automatic logic [7:0] cut_char(input logic [3:0] idx);
    case (idx)
      4'd0, 4'd1, 4'd2: cut_char = 8'h2E;
      4'd3:  cut_char = 8'h5B;
      4'd4:  cut_char = 8'h74;
      4'd5:  cut_char = 8'h72;
      4'd6:  cut_char = 8'h75;
      4'd7:  cut_char = 8'h6E;
      4'd8:  cut_char = 8'h63;
      4'd9:  cut_char = 8'h61;
      4'd10: cut_char = 8'h74;
      4'd11: cut_char = 8'h65;
      4'd12: cut_char = 8'h64;
      default: cut_char = 8'h5D;
    endcase
  endfunction

  function automatic logic is_format_cp(input logic [20:0] cp);
    is_format_cp = (cp >= 21'h80 && cp <= 21'h9F) || (cp >= 21'h200B && cp <= 21'h200F) ||
                   (cp >= 21'h202A && cp <= 21'h202E) || cp == 21'h2060 ||
                   (cp >= 21'h2066 && cp <= 21'h2069) || cp == 21'hFEFF;
  endfunction

endpackage

// ===== rtl/terminal_text_sanitizer.sv =====
// ----------------------------------------------------------------------------
// terminal_text_sanitizer
// byte-serial filter that makes untrusted text safe to print on a terminal
// ----------------------------------------------------------------------------
// latency: a plain byte, once accepted, passes fetch, dispatch, handle, finish
//   and release from the hold stage before it is presented on the output
// throughput: set by the single sequencer, which emits one byte a cycle while
//   the output is not stalled and takes no new word until the last is through
// reset: parser idle, counters clear, queue and output empty, limit 4096
// ----------------------------------------------------------------------------
module terminal_text_sanitizer #(
  parameter int unsigned SGR_PARAM_DEPTH = tts_pkg::SGR_PARAM_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_text_i,
  // output words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_of_run_o,
  output logic        end_of_output_o,
  // limit register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import tts_pkg::*;

  // output byte limit; the user must write it only while the block is quiet, the block does not enforce this
  logic [15:0] max_out_q;

  // queue handshake between classifier and sequencer
  logic        q_full, q_push, q_pop, q_valid;
  item_t       q_in, q_out;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_out_q <= MAX_OUT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_out_q <= cfg_data_i;
    end
  end

  // front: take words and tag byte classes
  tts_front u_front (
    .in_valid_i    (in_valid_i),
    .data_byte_i   (data_byte_i),
    .has_byte_i    (has_byte_i),
    .end_of_text_i (end_of_text_i),
    .in_stall_o    (in_stall_o),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (q_in)
  );

  // decoupling queue so either side can stall on its own
  tts_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out),
    .full_o  (q_full),
    .count_o (q_count)
  );

  // back: parser and byte emitter with hold stage and output register
  tts_back #(
    .SGR_PARAM_DEPTH (SGR_PARAM_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .max_out_i       (max_out_q),
    .q_valid_i       (q_valid),
    .q_item_i        (q_out),
    .q_pop_o         (q_pop),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .out_byte_o      (out_byte_o),
    .last_of_run_o   (last_of_run_o),
    .end_of_output_o (end_of_output_o)
  );

  // end of text only ever marks the last byte of a word's run
  a_eop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_output_o |-> last_of_run_o)
    else $error("end_of_output without last_of_run");

  // sequencer never pops an empty queue
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // occupancy stays within the queue depth
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("queue overfilled");

endmodule

// ===== rtl/tts_front.sv =====
// ----------------------------------------------------------------------------
// tts_front
// accepts input words and tags each byte with its character class
// ----------------------------------------------------------------------------
module tts_front (
  input  logic          in_valid_i,
  input  logic [7:0]    data_byte_i,
  input  logic          has_byte_i,
  input  logic          end_of_text_i,
  output logic          in_stall_o,
  input  logic          q_full_i,
  output logic          q_push_o,
  output tts_pkg::item_t q_item_o
);
  import tts_pkg::*;

  logic [7:0] b;
  assign b = data_byte_i;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_item_o          = '0;
    q_item_o.data     = b;
    q_item_o.has      = has_byte_i;
    q_item_o.fin      = end_of_text_i;
    q_item_o.is_esc   = (b == CH_ESC);
    q_item_o.is_ctrl  = (b < 8'h20) || (b == CH_DEL);
    q_item_o.is_ascii = !b[7];
    q_item_o.is_cont  = (b[7:6] == 2'b10);
    q_item_o.is_param = (b >= 8'h30 && b <= 8'h39) || (b == CH_SEMI);
    q_item_o.is_m     = (b == CH_M);
    q_item_o.is_lbr   = (b == CH_LBR);
    if (b[7:5] == 3'b110) begin
      q_item_o.lead_len  = 3'd2;
      q_item_o.lead_bits = b[4:0];
    end else if (b[7:4] == 4'b1110) begin
      q_item_o.lead_len  = 3'd3;
      q_item_o.lead_bits = {1'b0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      q_item_o.lead_len  = 3'd4;
      q_item_o.lead_bits = {2'b00, b[2:0]};
    end
  end

endmodule

// ===== rtl/tts_queue.sv =====
// ----------------------------------------------------------------------------
// tts_queue
// short item queue between the classifier and the sequencer
// ----------------------------------------------------------------------------
module tts_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tts_pkg::item_t item_i,
  input  logic           pop_i,
  output logic           valid_o,
  output tts_pkg::item_t item_o,
  output logic           full_o,
  output logic [$clog2(tts_pkg::QUEUE_DEPTH+1)-1:0] count_o
);
  import tts_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  item_t         mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign item_o  = mem_q[rd_q];
  assign count_o = cnt_q;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/tts_back.sv =====
// ----------------------------------------------------------------------------
// tts_back
// sequencer that parses escapes and utf-8 and emits one output byte a cycle while the output is not stalled
// ----------------------------------------------------------------------------
module tts_back #(
  parameter int unsigned SGR_PARAM_DEPTH = tts_pkg::SGR_PARAM_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [15:0]    max_out_i,
  input  logic           q_valid_i,
  input  tts_pkg::item_t q_item_i,
  output logic           q_pop_o,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output logic [7:0]     out_byte_o,
  output logic           last_of_run_o,
  output logic           end_of_output_o
);
  import tts_pkg::*;

  localparam int unsigned CAP = (SGR_PARAM_DEPTH > SGR_CAP_MAX) ? SGR_CAP_MAX : SGR_PARAM_DEPTH;
  localparam int unsigned SIW = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int unsigned CW  = $clog2(CAP + 1);
  localparam int unsigned IW  = (CAP + 3 > 8) ? $clog2(CAP + 3) : 3;

  localparam logic [3:0] S_FETCH  = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_HANDLE = 4'd2;
  localparam logic [3:0] S_HEX    = 4'd3;
  localparam logic [3:0] S_CUT    = 4'd4;
  localparam logic [3:0] S_CSIFL  = 4'd5;
  localparam logic [3:0] S_UTFFL  = 4'd6;
  localparam logic [3:0] S_SGR    = 4'd7;
  localparam logic [3:0] S_UESC   = 4'd8;
  localparam logic [3:0] S_UPASS  = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;
  localparam logic [3:0] S_END    = 4'd11;

  logic [3:0]    state_q, state_d, ret_q, ret_d, cont_q, cont_d;
  logic [1:0]    phase_q, phase_d;
  item_t         item_q, item_d;
  logic [7:0]    store_q [CAP];
  logic [CW-1:0] scnt_q, scnt_d;
  logic [7:0]    pend_q [3];
  logic [2:0]    exp_q, exp_d;
  logic [1:0]    seen_q, seen_d;
  logic [20:0]   cp_q, cp_d;
  logic [16:0]   ecount_q, ecount_d;
  logic          trunc_q, trunc_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [1:0]    hidx_q, hidx_d;
  logic [3:0]    cidx_q, cidx_d;
  logic [7:0]    hval_q, hval_d;
  logic          held_v_q, held_v_d;
  logic [7:0]    held_q, held_d;
  logic          out_v_q, out_v_d;
  logic [7:0]    obyte_q;
  logic          olast_q, oeop_q;

  logic          adv, out_free, cut_now;
  logic          emit_v, emit_cnt, end_push, load_out;
  logic [7:0]    emit_b, b, st_rd, pd_rd;
  logic          st_we, pd_we;
  logic [1:0]    pd_wa, pd_ra;
  logic [SIW-1:0] st_ra;
  logic [20:0]   cp_new, cp_min;
  logic          more, bad;

  assign b        = item_q.data;
  assign out_free = !out_v_q || !out_stall_i;
  assign adv      = !held_v_q || out_free;
  assign cut_now  = !trunc_q && (ecount_q >= {1'b0, max_out_i});
  assign cp_new   = {cp_q[14:0], b[5:0]};
  assign cp_min   = (exp_q == 3'd2) ? 21'h80 : (exp_q == 3'd3) ? 21'h800 : 21'h10000;
  assign more     = ({1'b0, seen_q} + 3'd1 < exp_q) && (seen_q < 2'd3);
  assign bad      = (cp_new < cp_min) || (cp_new > 21'h10FFFF) ||
                    (cp_new >= 21'hD800 && cp_new <= 21'hDFFF);

  // single read port per store
  assign st_ra = (state_q == S_SGR) ? SIW'(idx_q - IW'(2)) : SIW'(idx_q - IW'(1));
  assign st_rd = store_q[st_ra];
  assign pd_ra = (state_q == S_UTFFL || state_q == S_UPASS) ? idx_q[1:0] : 2'd0;
  assign pd_rd = pend_q[pd_ra];
  assign pd_wa = (state_q == S_HANDLE) ? 2'd0 : seen_q;

  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    cont_d   = cont_q;
    phase_d  = phase_q;
    item_d   = item_q;
    scnt_d   = scnt_q;
    exp_d    = exp_q;
    seen_d   = seen_q;
    cp_d     = cp_q;
    ecount_d = ecount_q;
    trunc_d  = trunc_q;
    idx_d    = idx_q;
    hidx_d   = hidx_q;
    cidx_d   = cidx_q;
    hval_d   = hval_q;
    held_v_d = held_v_q;
    held_d   = held_q;
    emit_v   = 1'b0;
    emit_cnt = 1'b0;
    emit_b   = '0;
    end_push = 1'b0;
    q_pop_o  = 1'b0;
    st_we    = 1'b0;
    pd_we    = 1'b0;
    if (adv) begin
      case (state_q)
        S_FETCH: begin
          if (q_valid_i) begin
            q_pop_o = 1'b1;
            item_d  = q_item_i;
            state_d = (q_item_i.has && !trunc_q) ? S_DISP : S_FIN;
          end
        end
        S_DISP: begin
          case (phase_q)
            PH_ESC: begin
              if (item_q.is_lbr) begin
                phase_d = PH_CSI;
                scnt_d  = '0;
                state_d = S_FIN;
              end else begin
                phase_d = PH_IDLE;
                hval_d  = CH_ESC;
                hidx_d  = '0;
                ret_d   = S_HANDLE;
                state_d = S_HEX;
              end
            end
            PH_CSI: begin
              if (item_q.is_param && scnt_q < CW'(CAP)) begin
                st_we   = 1'b1;
                scnt_d  = scnt_q + CW'(1);
                state_d = S_FIN;
              end else if (item_q.is_m) begin
                idx_d   = '0;
                state_d = S_SGR;
              end else begin
                phase_d = PH_IDLE;
                hval_d  = CH_ESC;
                hidx_d  = '0;
                ret_d   = S_CSIFL;
                idx_d   = '0;
                cont_d  = S_HANDLE;
                state_d = S_HEX;
              end
            end
            PH_UTF8: begin
              if (item_q.is_cont && more) begin
                pd_we   = 1'b1;
                seen_d  = seen_q + 2'd1;
                cp_d    = cp_new;
                state_d = S_FIN;
              end else if (!item_q.is_cont || bad) begin
                phase_d = PH_IDLE;
                hval_d  = pd_rd;
                hidx_d  = '0;
                ret_d   = S_UTFFL;
                idx_d   = IW'(1);
                cont_d  = S_HANDLE;
                state_d = S_HEX;
              end else begin
                phase_d = PH_IDLE;
                cp_d    = cp_new;
                idx_d   = '0;
                state_d = is_format_cp(cp_new) ? S_UESC : S_UPASS;
              end
            end
            default: state_d = S_HANDLE;
          endcase
        end
        S_HANDLE: begin
          state_d = S_FIN;
          if (trunc_q) begin
            state_d = S_FIN;
          end else if (cut_now) begin
            trunc_d = 1'b1;
            phase_d = PH_IDLE;
            cidx_d  = '0;
            ret_d   = S_FIN;
            state_d = S_CUT;
          end else if (item_q.is_esc) begin
            phase_d = PH_ESC;
          end else if (item_q.is_ctrl || (!item_q.is_ascii && item_q.lead_len == 3'd0)) begin
            hval_d  = b;
            hidx_d  = '0;
            ret_d   = S_FIN;
            state_d = S_HEX;
          end else if (item_q.is_ascii) begin
            emit_v   = 1'b1;
            emit_cnt = 1'b1;
            emit_b   = b;
          end else begin
            cp_d    = {16'd0, item_q.lead_bits};
            exp_d   = item_q.lead_len;
            pd_we   = 1'b1;
            seen_d  = 2'd1;
            phase_d = PH_UTF8;
          end
        end
        S_HEX: begin
          emit_v   = 1'b1;
          emit_cnt = 1'b1;
          case (hidx_q)
            2'd0:    emit_b = CH_BSL;
            2'd1:    emit_b = CH_X;
            2'd2:    emit_b = hex_char(hval_q[7:4]);
            default: emit_b = hex_char(hval_q[3:0]);
          endcase
          hidx_d = hidx_q + 2'd1;
          if (hidx_q == 2'd3) begin
            state_d = ret_q;
          end
        end
        S_CUT: begin
          emit_v = 1'b1;
          emit_b = cut_char(cidx_q);
          cidx_d = cidx_q + 4'd1;
          if (cidx_q == 4'(CUT_LEN - 1)) begin
            state_d = ret_q;
          end
        end
        S_CSIFL: begin
          if (idx_q > IW'(scnt_q)) begin
            scnt_d  = '0;
            state_d = cont_q;
          end else begin
            idx_d = idx_q + IW'(1);
            if (cut_now) begin
              trunc_d = 1'b1;
              phase_d = PH_IDLE;
              cidx_d  = '0;
              ret_d   = S_CSIFL;
              state_d = S_CUT;
            end else if (!trunc_q) begin
              emit_v   = 1'b1;
              emit_cnt = 1'b1;
              emit_b   = (idx_q == '0) ? CH_LBR : st_rd;
            end
          end
        end
        S_UTFFL: begin
          if (idx_q >= IW'(seen_q)) begin
            state_d = cont_q;
          end else begin
            idx_d = idx_q + IW'(1);
            if (cut_now) begin
              trunc_d = 1'b1;
              phase_d = PH_IDLE;
              cidx_d  = '0;
              ret_d   = S_UTFFL;
              state_d = S_CUT;
            end else if (!trunc_q) begin
              hval_d  = pd_rd;
              hidx_d  = '0;
              ret_d   = S_UTFFL;
              state_d = S_HEX;
            end
          end
        end
        S_SGR: begin
          emit_v   = 1'b1;
          emit_cnt = 1'b1;
          idx_d    = idx_q + IW'(1);
          if (idx_q == '0) begin
            emit_b = CH_ESC;
          end else if (idx_q == IW'(1)) begin
            emit_b = CH_LBR;
          end else if (idx_q == IW'(scnt_q) + IW'(2)) begin
            emit_b  = CH_M;
            scnt_d  = '0;
            phase_d = PH_IDLE;
            state_d = S_FIN;
          end else begin
            emit_b = st_rd;
          end
        end
        S_UESC: begin
          emit_v   = 1'b1;
          emit_cnt = 1'b1;
          idx_d    = idx_q + IW'(1);
          case (idx_q)
            IW'(0):  emit_b = CH_BSL;
            IW'(1):  emit_b = CH_U;
            IW'(2):  emit_b = hex_char(cp_q[15:12]);
            IW'(3):  emit_b = hex_char(cp_q[11:8]);
            IW'(4):  emit_b = hex_char(cp_q[7:4]);
            default: emit_b = hex_char(cp_q[3:0]);
          endcase
          if (idx_q == IW'(5)) begin
            state_d = S_FIN;
          end
        end
        S_UPASS: begin
          emit_v   = 1'b1;
          emit_cnt = 1'b1;
          idx_d    = idx_q + IW'(1);
          if (idx_q == IW'(seen_q)) begin
            emit_b  = b;
            state_d = S_FIN;
          end else begin
            emit_b = pd_rd;
          end
        end
        S_FIN: begin
          state_d = S_END;
          if (item_q.fin && !trunc_q) begin
            case (phase_q)
              PH_ESC: begin
                phase_d = PH_IDLE;
                hval_d  = CH_ESC;
                hidx_d  = '0;
                ret_d   = S_END;
                state_d = S_HEX;
              end
              PH_CSI: begin
                phase_d = PH_IDLE;
                hval_d  = CH_ESC;
                hidx_d  = '0;
                ret_d   = S_CSIFL;
                idx_d   = '0;
                cont_d  = S_END;
                state_d = S_HEX;
              end
              PH_UTF8: begin
                phase_d = PH_IDLE;
                hval_d  = pd_rd;
                hidx_d  = '0;
                ret_d   = S_UTFFL;
                idx_d   = IW'(1);
                cont_d  = S_END;
                state_d = S_HEX;
              end
              default: state_d = S_END;
            endcase
          end
        end
        S_END: begin
          end_push = held_v_q;
          held_v_d = 1'b0;
          state_d  = S_FETCH;
          if (item_q.fin) begin
            phase_d  = PH_IDLE;
            scnt_d   = '0;
            ecount_d = '0;
            trunc_d  = 1'b0;
          end
        end
        default: state_d = S_FETCH;
      endcase
    end
    // emitted byte waits in the hold stage until the next one shows up or the word ends
    if (emit_v) begin
      held_d   = emit_b;
      held_v_d = 1'b1;
      if (emit_cnt && ecount_q != 17'h1FFFF) begin
        ecount_d = ecount_q + 17'd1;
      end
    end
  end

  assign load_out = (emit_v && held_v_q) || end_push;

  always_comb begin
    out_v_d = out_v_q && out_stall_i;
    if (load_out) begin
      out_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_FETCH;
      ret_q    <= S_FETCH;
      cont_q   <= S_FETCH;
      phase_q  <= PH_IDLE;
      scnt_q   <= '0;
      exp_q    <= '0;
      seen_q   <= '0;
      cp_q     <= '0;
      ecount_q <= '0;
      trunc_q  <= 1'b0;
      idx_q    <= '0;
      hidx_q   <= '0;
      cidx_q   <= '0;
      held_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      cont_q   <= cont_d;
      phase_q  <= phase_d;
      scnt_q   <= scnt_d;
      exp_q    <= exp_d;
      seen_q   <= seen_d;
      cp_q     <= cp_d;
      ecount_q <= ecount_d;
      trunc_q  <= trunc_d;
      idx_q    <= idx_d;
      hidx_q   <= hidx_d;
      cidx_q   <= cidx_d;
      held_v_q <= held_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    hval_q <= hval_d;
    held_q <= held_d;
    if (st_we) begin
      store_q[SIW'(scnt_q)] <= b;
    end
    if (pd_we) begin
      pend_q[pd_wa] <= b;
    end
    if (load_out) begin
      obyte_q <= held_q;
      olast_q <= end_push;
      oeop_q  <= end_push && item_q.fin;
    end
  end

  assign out_valid_o     = out_v_q;
  assign out_byte_o      = obyte_q;
  assign last_of_run_o   = olast_q;
  assign end_of_output_o = oeop_q;

endmodule
